// File: hdl/tqr_pkg.sv
`default_nettype none

package tqr_pkg;

  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;
  localparam int COORD_BITS    = 12;

  localparam int QX_W    = $clog2(SCREEN_WIDTH);
  localparam int QY_W    = $clog2(SCREEN_HEIGHT);
  localparam int STEP_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * STEP_W;
  localparam int EDGE_W  = PROD_W + 2;
  localparam int COLOR_W = 32;
  localparam int COV_W   = 4;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [STEP_W-1:0]     step_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [EDGE_W-1:0]     edge_t;

  function automatic step_t coord_ext(coord_t c);
    return {c[COORD_BITS-1], c};
  endfunction

  function automatic edge_t step_ext(step_t s);
    return {{(EDGE_W-STEP_W){s[STEP_W-1]}}, s};
  endfunction

  function automatic edge_t prod_ext(prod_t p);
    return {{(EDGE_W-PROD_W){p[PROD_W-1]}}, p};
  endfunction

endpackage

`default_nettype wire

// File: hdl/triangle_quad_rasterizer.sv
`default_nettype none

// Edge-function triangle traversal emitting 2x2 quads.
// Input channel (in_valid/in_ready): opcode 0 loads three vertices and a
// fill color, opcode 1 asks for the next quad of the loaded triangle.
// Result channel (out_valid/out_ready): one quad per step transaction while
// a triangle is active: position, 4-bit coverage, color and a last flag.
// A load sets up the box and edge steps in the accept cycle and the edge
// start values in the following cycle; in_ready is low during that cycle.
// A step's result is in the result register in the cycle after acceptance,
// and steps are taken one per cycle while the receiver takes each result,
// so a traversal runs at one quad per clock. A step while idle is taken and
// gives no result. A load drops any traversal in progress.
// The result register frees in the cycle it is taken, so a stalled
// receiver holds in_ready low only while the result register is full.
// Reset (rst_n low, synchronous) leaves the block idle with no result
// pending and no setup in flight.
module triangle_quad_rasterizer_core
  import tqr_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,

  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire                  in_opcode,
  input  wire signed [COORD_BITS-1:0] in_vert0_x,
  input  wire signed [COORD_BITS-1:0] in_vert0_y,
  input  wire signed [COORD_BITS-1:0] in_vert1_x,
  input  wire signed [COORD_BITS-1:0] in_vert1_y,
  input  wire signed [COORD_BITS-1:0] in_vert2_x,
  input  wire signed [COORD_BITS-1:0] in_vert2_y,
  input  wire        [COLOR_W-1:0]    in_fill_color,

  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [QX_W-1:0]      out_quad_x,
  output logic [QY_W-1:0]      out_quad_y,
  output logic [COV_W-1:0]     out_coverage,
  output logic [COLOR_W-1:0]   out_pixel_color,
  output logic                 out_last_quad
);

  // control
  logic active_r, active_nxt;
  logic pend_r, pend_nxt;
  logic oval_r, oval_nxt;

  // traversal state
  logic [QX_W-1:0]    minx_r, maxx_r, cx_r;
  logic [QY_W-1:0]    maxy_r, cy_r;
  step_t              dx_r[3], dy_r[3], ox_r[3], oy_r[3];
  edge_t              row_r[3], cur_r[3];
  logic [COLOR_W-1:0] color_r;

  // result register
  logic [QX_W-1:0]    oqx_r;
  logic [QY_W-1:0]    oqy_r;
  logic [COV_W-1:0]   ocov_r;
  logic [COLOR_W-1:0] ocol_r;
  logic               olast_r;

  logic in_acc, do_load, do_step;

  assign in_ready = !pend_r && (!oval_r || out_ready);
  assign in_acc   = in_valid && in_ready;
  assign do_load  = in_acc && (in_opcode == OP_LOAD);
  assign do_step  = in_acc && (in_opcode == OP_STEP) && active_r;

  // ---- load setup: box and edge steps ----
  coord_t vx[3], vy[3], vxn[3], vyn[3];
  coord_t minx, miny, maxx, maxy;
  step_t  minx_c, miny_c, maxx_c, maxy_c, minx_a, miny_a;
  step_t  ld_dx[3], ld_dy[3], ld_ox[3], ld_oy[3];
  logic   ld_active;

  always_comb begin
    vx[0] = in_vert0_x; vy[0] = in_vert0_y;
    vx[1] = in_vert1_x; vy[1] = in_vert1_y;
    vx[2] = in_vert2_x; vy[2] = in_vert2_y;
    vxn[0] = vx[1]; vyn[0] = vy[1];
    vxn[1] = vx[2]; vyn[1] = vy[2];
    vxn[2] = vx[0]; vyn[2] = vy[0];

    minx = vx[0]; maxx = vx[0];
    miny = vy[0]; maxy = vy[0];
    for (int i = 1; i < 3; i++) begin
      if (vx[i] < minx) minx = vx[i];
      if (vx[i] > maxx) maxx = vx[i];
      if (vy[i] < miny) miny = vy[i];
      if (vy[i] > maxy) maxy = vy[i];
    end

    minx_c = (minx < 0) ? '0 : coord_ext(minx);
    miny_c = (miny < 0) ? '0 : coord_ext(miny);
    maxx_c = (coord_ext(maxx) > step_t'(SCREEN_WIDTH - 1))
           ? step_t'(SCREEN_WIDTH - 1) : coord_ext(maxx);
    maxy_c = (coord_ext(maxy) > step_t'(SCREEN_HEIGHT - 1))
           ? step_t'(SCREEN_HEIGHT - 1) : coord_ext(maxy);
    minx_a = {minx_c[STEP_W-1:1], 1'b0};
    miny_a = {miny_c[STEP_W-1:1], 1'b0};
    ld_active = (minx_a <= maxx_c) && (miny_a <= maxy_c);

    for (int i = 0; i < 3; i++) begin
      ld_dx[i] = coord_ext(vy[i]) - coord_ext(vyn[i]);
      ld_dy[i] = coord_ext(vxn[i]) - coord_ext(vx[i]);
      ld_ox[i] = minx_a - coord_ext(vx[i]);
      ld_oy[i] = miny_a - coord_ext(vy[i]);
    end
  end

  // ---- second setup cycle: edge values at the box corner ----
  prod_t px[3], py[3];
  edge_t start_e[3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      px[i] = dx_r[i] * ox_r[i];
      py[i] = dy_r[i] * oy_r[i];
      start_e[i] = prod_ext(px[i]) + prod_ext(py[i]);
    end
  end

  // ---- quad evaluation ----
  logic [QX_W:0] cx_p1, cx_p2, maxx_w;
  logic [QY_W:0] cy_p1, cy_p2, maxy_w;
  logic in_x1, in_y1, more_x, more_y;
  edge_t e_tr[3], e_bl[3], e_br[3];
  logic tl_in, tr_in, bl_in, br_in;
  logic [COV_W-1:0] cov;

  always_comb begin
    cx_p1  = {1'b0, cx_r} + 1'b1;
    cx_p2  = {1'b0, cx_r} + 2'd2;
    cy_p1  = {1'b0, cy_r} + 1'b1;
    cy_p2  = {1'b0, cy_r} + 2'd2;
    maxx_w = {1'b0, maxx_r};
    maxy_w = {1'b0, maxy_r};
    in_x1  = cx_p1 <= maxx_w;
    in_y1  = cy_p1 <= maxy_w;
    more_x = cx_p2 <= maxx_w;
    more_y = cy_p2 <= maxy_w;

    tl_in = 1'b1; tr_in = 1'b1; bl_in = 1'b1; br_in = 1'b1;
    for (int i = 0; i < 3; i++) begin
      e_tr[i] = cur_r[i] + step_ext(dx_r[i]);
      e_bl[i] = cur_r[i] + step_ext(dy_r[i]);
      e_br[i] = e_tr[i] + step_ext(dy_r[i]);
      tl_in = tl_in & ~cur_r[i][EDGE_W-1];
      tr_in = tr_in & ~e_tr[i][EDGE_W-1];
      bl_in = bl_in & ~e_bl[i][EDGE_W-1];
      br_in = br_in & ~e_br[i][EDGE_W-1];
    end

    cov[0] = tl_in;
    cov[1] = in_x1 && tr_in;
    cov[2] = in_y1 && bl_in;
    cov[3] = in_x1 && in_y1 && br_in;
  end

  // ---- control ----
  always_comb begin
    active_nxt = active_r;
    pend_nxt   = 1'b0;
    oval_nxt   = oval_r && !out_ready;
    if (do_load) begin
      active_nxt = ld_active;
      pend_nxt   = 1'b1;
    end else if (do_step) begin
      oval_nxt = 1'b1;
      if (!more_x && !more_y) active_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pend_r   <= 1'b0;
      oval_r   <= 1'b0;
    end else begin
      active_r <= active_nxt;
      pend_r   <= pend_nxt;
      oval_r   <= oval_nxt;
    end
  end

  // ---- datapath ----
  always_ff @(posedge clk) begin
    if (do_load) begin
      minx_r  <= minx_a[QX_W-1:0];
      maxx_r  <= maxx_c[QX_W-1:0];
      maxy_r  <= maxy_c[QY_W-1:0];
      cx_r    <= minx_a[QX_W-1:0];
      cy_r    <= miny_a[QY_W-1:0];
      color_r <= in_fill_color;
      for (int i = 0; i < 3; i++) begin
        dx_r[i] <= ld_dx[i];
        dy_r[i] <= ld_dy[i];
        ox_r[i] <= ld_ox[i];
        oy_r[i] <= ld_oy[i];
      end
    end else if (pend_r) begin
      for (int i = 0; i < 3; i++) begin
        row_r[i] <= start_e[i];
        cur_r[i] <= start_e[i];
      end
    end else if (do_step) begin
      if (more_x) begin
        cx_r <= cx_p2[QX_W-1:0];
        for (int i = 0; i < 3; i++) begin
          cur_r[i] <= cur_r[i] + (step_ext(dx_r[i]) <<< 1);
        end
      end else if (more_y) begin
        cx_r <= minx_r;
        cy_r <= cy_p2[QY_W-1:0];
        for (int i = 0; i < 3; i++) begin
          row_r[i] <= row_r[i] + (step_ext(dy_r[i]) <<< 1);
          cur_r[i] <= row_r[i] + (step_ext(dy_r[i]) <<< 1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_step) begin
      oqx_r   <= cx_r;
      oqy_r   <= cy_r;
      ocov_r  <= cov;
      ocol_r  <= color_r;
      olast_r <= !more_x && !more_y;
    end
  end

  assign out_valid       = oval_r;
  assign out_quad_x      = oqx_r;
  assign out_quad_y      = oqy_r;
  assign out_coverage    = ocov_r;
  assign out_pixel_color = ocol_r;
  assign out_last_quad   = olast_r;

endmodule

`default_nettype wire
